@@ rtl/cmao_pkg.sv @@
// Package with shared widths, codes and the item type of the moving average block.
`timescale 1ns / 1ps
package cmao_pkg;

  // Field widths.
  localparam int SAMPLE_W    = 10;
  localparam int LEVEL_W     = 11;
  localparam int CALIB_CNT_W = 4;
  localparam int CFG_IDX_W   = 1;

  // Command codes.
  localparam logic CMD_SENSE = 1'b0;
  localparam logic CMD_CALIB = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_HIGH = 1'b1;

  // Reset values of the clamp bounds.
  localparam logic [SAMPLE_W-1:0] CLAMP_LOW_RST  = '0;
  localparam logic [SAMPLE_W-1:0] CLAMP_HIGH_RST = '1;

  // One input transaction as it travels through the pipeline.
  typedef struct packed {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
  } item_t;

endpackage

@@ rtl/cmao_window_mem.sv @@
// Ring memory of readings with registered read, entry valid bits and write forwarding.
`timescale 1ns / 1ps
module cmao_window_mem
  import cmao_pkg::*;
#(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output logic [SAMPLE_W-1:0] rd_data,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  logic [SAMPLE_W-1:0] wr_data
);

  logic [SAMPLE_W-1:0] mem_r [DEPTH];
  logic [SAMPLE_W-1:0] q_r;
  logic [SAMPLE_W-1:0] fwd_data_r;
  logic [DEPTH-1:0]    vld_r;
  logic                hit_r;
  logic                fwd_r;

  // Storage array: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r        <= mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Entry valid bits make never-written entries read as zero after reset.
  // A write to the address being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        hit_r <= vld_r[rd_addr];
        fwd_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : (hit_r ? q_r : '0);

endmodule

@@ rtl/cmao_accum.sv @@
// Clamp, running total update and calibration offset tracking.
`timescale 1ns / 1ps
module cmao_accum
  import cmao_pkg::*;
#(
  parameter int CALIB_SAMPLES = 11,
  parameter int TOT_W         = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  item_t               item,
  input  logic [SAMPLE_W-1:0] old_value,
  input  logic [SAMPLE_W-1:0] clamp_low,
  input  logic [SAMPLE_W-1:0] clamp_high,
  output logic [SAMPLE_W-1:0] clamped,
  output logic [TOT_W-1:0]    total_nxt,
  output logic [SAMPLE_W-1:0] offset_nxt
);

  logic [TOT_W-1:0]       total_r;
  logic [SAMPLE_W-1:0]    offset_r;
  logic [SAMPLE_W-1:0]    peak_r;
  logic [SAMPLE_W-1:0]    peak_nxt;
  logic [CALIB_CNT_W-1:0] count_r;
  logic [CALIB_CNT_W-1:0] count_nxt;
  logic [CALIB_CNT_W-1:0] count_inc;

  // Clamp a sense sample; the low bound is tested first when the bounds cross.
  always_comb begin
    if (item.sample < clamp_low) begin
      clamped = clamp_low;
    end else if (item.sample > clamp_high) begin
      clamped = clamp_high;
    end else begin
      clamped = item.sample;
    end
  end

  assign count_inc = count_r + CALIB_CNT_W'(1);

  // Next state for the total and the calibration run.
  always_comb begin
    total_nxt  = total_r;
    offset_nxt = offset_r;
    peak_nxt   = peak_r;
    count_nxt  = count_r;
    if (item.command == CMD_CALIB) begin
      if ((count_r == '0) || (item.sample > peak_r)) begin
        peak_nxt = item.sample;
      end
      if (count_inc >= CALIB_CNT_W'(CALIB_SAMPLES)) begin
        offset_nxt = peak_nxt;
        count_nxt  = '0;
      end else begin
        count_nxt = count_inc;
      end
    end else begin
      // A sense sample abandons any calibration run in progress.
      count_nxt = '0;
      total_nxt = total_r - TOT_W'(old_value) + TOT_W'(clamped);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      offset_r <= '0;
      peak_r   <= '0;
      count_r  <= '0;
    end else if (fire) begin
      total_r  <= total_nxt;
      offset_r <= offset_nxt;
      peak_r   <= peak_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ rtl/cmao_scale.sv @@
// Average by reciprocal multiply, offset subtraction and the output register.
`timescale 1ns / 1ps
module cmao_scale
  import cmao_pkg::*;
#(
  parameter int NUM_READINGS = 8,
  parameter int TOT_W        = 13
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  logic [TOT_W-1:0]          total,
  input  logic [SAMPLE_W-1:0]       offset,
  output logic                      s2_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [LEVEL_W-1:0] out_level
);

  // Exact floor division for every total below 2**TOT_W.
  localparam int SHIFT   = TOT_W + $clog2(NUM_READINGS);
  localparam int RECIP_W = SHIFT + 1;
  localparam int PROD_W  = TOT_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + NUM_READINGS - 1) / NUM_READINGS);

  logic                      s2_v_r;
  logic [PROD_W-1:0]         prod_r;
  logic [SAMPLE_W-1:0]       off_r;
  logic                      out_v_r;
  logic signed [LEVEL_W-1:0] level_r;
  logic signed [LEVEL_W-1:0] level_nxt;
  logic                      out_ready;
  logic [SAMPLE_W-1:0]       avg;

  assign out_ready = !out_v_r || !out_stall;
  assign s2_ready  = !s2_v_r || out_ready;

  // Product stage.
  always_ff @(posedge clk) begin
    if (s2_ready && push) begin
      prod_r <= PROD_W'(total) * PROD_W'(RECIP);
      off_r  <= offset;
    end
  end

  assign avg       = prod_r[SHIFT +: SAMPLE_W];
  assign level_nxt = signed'({1'b0, avg}) - signed'({1'b0, off_r});

  // Output register.
  always_ff @(posedge clk) begin
    if (out_ready && s2_v_r) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_v_r <= push;
      end
      if (out_ready) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_level = level_r;

endmodule

@@ rtl/clamped_moving_average_offset.sv @@
// Top level of the clamped moving average with calibration offset.
//
//   Channel | Direction | Handshake          | Payload
//   in      | input     | in_valid/in_stall  | in_command, in_sample
//   out     | output    | out_valid/out_stall| out_level
//   cfg     | input     | cfg_we             | cfg_index, cfg_wdata
//
// One transaction is accepted per cycle while in_stall is low; a sense sample's
// result reaches out_level through stage 1 (window read), the product register
// (total update, reciprocal multiply) and the output register (offset subtraction).
// The ring memory's read is registered and the running total is a single register.
// Reset is synchronous and active low; entries of the ring read as zero until
// first written. A stalled output holds its result while upstream stages fill.
`timescale 1ns / 1ps
module clamped_moving_average_offset
  import cmao_pkg::*;
#(
  parameter int NUM_READINGS  = 8,
  parameter int CALIB_SAMPLES = 11
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_command,
  input  logic [SAMPLE_W-1:0]       in_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [LEVEL_W-1:0] out_level,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [SAMPLE_W-1:0]       cfg_wdata
);

  localparam int ADDR_W = (NUM_READINGS > 1) ? $clog2(NUM_READINGS) : 1;
  localparam int TOT_W  = SAMPLE_W + $clog2(NUM_READINGS);

  logic [SAMPLE_W-1:0] clamp_low_r;
  logic [SAMPLE_W-1:0] clamp_high_r;
  logic [ADDR_W-1:0]   rd_slot_r;
  logic [ADDR_W-1:0]   rd_slot_nxt;
  logic                s1_v_r;
  item_t               s1_item_r;
  logic [ADDR_W-1:0]   s1_slot_r;
  logic                accept;
  logic                rd_en;
  logic                s1_fire;
  logic                s1_sense;
  logic                s2_ready;
  logic [SAMPLE_W-1:0] old_value;
  logic [SAMPLE_W-1:0] clamped;
  logic [TOT_W-1:0]    total_nxt;
  logic [SAMPLE_W-1:0] offset_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clamp_low_r  <= CLAMP_LOW_RST;
      clamp_high_r <= CLAMP_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLAMP_LOW:  clamp_low_r  <= cfg_wdata;
        CFG_CLAMP_HIGH: clamp_high_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage 1 fires when it holds a transaction that can leave.
  assign s1_sense = (s1_item_r.command == CMD_SENSE);
  assign s1_fire  = s1_v_r && (!s1_sense || s2_ready);
  assign in_stall = s1_v_r && !s1_fire;
  assign accept   = in_valid && !in_stall;
  assign rd_en    = accept && (in_command == CMD_SENSE);

  // Ring pointer advances once per accepted sense sample.
  always_comb begin
    rd_slot_nxt = rd_slot_r;
    if (rd_en) begin
      if (rd_slot_r == ADDR_W'(NUM_READINGS - 1)) begin
        rd_slot_nxt = '0;
      end else begin
        rd_slot_nxt = rd_slot_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= '{command: in_command, sample: in_sample};
      s1_slot_r <= rd_slot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_slot_r <= '0;
      s1_v_r    <= 1'b0;
    end else begin
      rd_slot_r <= rd_slot_nxt;
      if (accept || s1_fire) begin
        s1_v_r <= accept;
      end
    end
  end

  cmao_window_mem #(
    .DEPTH  (NUM_READINGS),
    .ADDR_W (ADDR_W)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_slot_r),
    .rd_data (old_value),
    .wr_en   (s1_fire && s1_sense),
    .wr_addr (s1_slot_r),
    .wr_data (clamped)
  );

  cmao_accum #(
    .CALIB_SAMPLES (CALIB_SAMPLES),
    .TOT_W         (TOT_W)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (s1_fire),
    .item       (s1_item_r),
    .old_value  (old_value),
    .clamp_low  (clamp_low_r),
    .clamp_high (clamp_high_r),
    .clamped    (clamped),
    .total_nxt  (total_nxt),
    .offset_nxt (offset_nxt)
  );

  cmao_scale #(
    .NUM_READINGS (NUM_READINGS),
    .TOT_W        (TOT_W)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_fire && s1_sense),
    .total     (total_nxt),
    .offset    (offset_nxt),
    .s2_ready  (s2_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level)
  );

  // An empty first stage always takes a transaction.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> !in_stall)
    else $error("input stalled with an empty first stage");

  // A transaction enters stage 1 only as the one before it leaves.
  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && s1_v_r) |-> s1_fire)
    else $error("stage 1 overwritten before it fired");

  // The ring pointer stays inside the window.
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_slot_r <= ADDR_W'(NUM_READINGS - 1))
    else $error("ring pointer out of range");

endmodule

@@ tb/clamped_moving_average_offset_test.sv @@
// Self-checking testbench for the clamped moving average with calibration offset.
`timescale 1ns / 1ps
module clamped_moving_average_offset_test;
  import cmao_pkg::*;

  localparam int RING_DEPTH   = 8;
  localparam int CALIB_RUN    = 11;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 325;
  localparam int MAX_WAIT     = 13;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic                command;
    logic [SAMPLE_W-1:0] sample;
  } reading_t;

  logic                      clk;
  logic                      rst_n      = 1'b0;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic                      in_command = CMD_SENSE;
  logic [SAMPLE_W-1:0]       in_sample  = '0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index  = CFG_CLAMP_LOW;
  logic [SAMPLE_W-1:0]       cfg_wdata  = '0;

  // Readings waiting to be offered and levels waiting to come out.
  reading_t                  pending_readings[$];
  logic signed [LEVEL_W-1:0] expected_levels[$];

  // Mirror of the block's state and clamp bounds.
  logic [SAMPLE_W-1:0] ring_mem[RING_DEPTH];
  logic [12:0]         ring_sum;
  int                  ring_ptr;
  logic [SAMPLE_W-1:0] cal_offset;
  logic [SAMPLE_W-1:0] cal_peak;
  int                  cal_seen;
  logic [SAMPLE_W-1:0] lo_bound;
  logic [SAMPLE_W-1:0] hi_bound;

  // Handshake bookkeeping shared between the clocked processes.
  bit  in_took;
  bit  out_took;
  bit  tx_burst;
  bit  rx_burst;
  bit  hold_req;
  int  in_gap;
  int  out_wait;
  int  hold_left;

  int  pushed_cnt;
  int  accepted_cnt;
  int  checked_cnt;
  int  commit_cnt;
  int  setting_cnt;
  int  err_cnt;
  int  cycle_cnt;

  clamped_moving_average_offset #(
    .NUM_READINGS (RING_DEPTH),
    .CALIB_SAMPLES(CALIB_RUN)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_command(in_command),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_level (out_level),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_LIMIT) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
  endtask

  // Advances the mirrored state by one accepted reading and queues the level of a sense reading.
  task automatic predict_level(input logic cmd, input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] kept;
    logic [SAMPLE_W-1:0] avg;
    if (cmd == CMD_CALIB) begin
      // The first reading of a run loads the peak; the last one commits it.
      if (cal_seen == 0 || raw > cal_peak) cal_peak = raw;
      cal_seen++;
      if (cal_seen >= CALIB_RUN) begin
        cal_offset = cal_peak;
        cal_seen   = 0;
        commit_cnt++;
      end
    end else begin
      cal_seen = 0;
      // The low bound is tested first when the bounds are crossed.
      if (raw < lo_bound) kept = lo_bound;
      else if (raw > hi_bound) kept = hi_bound;
      else kept = raw;
      ring_sum = ring_sum - 13'(ring_mem[ring_ptr]) + 13'(kept);
      ring_mem[ring_ptr] = kept;
      ring_ptr = (ring_ptr == RING_DEPTH - 1) ? 0 : ring_ptr + 1;
      avg = SAMPLE_W'(ring_sum / RING_DEPTH);
      expected_levels.push_back($signed({1'b0, avg}) - $signed({1'b0, cal_offset}));
    end
  endtask

  task automatic queue_reading(input logic cmd, input int raw);
    reading_t r;
    r.command = cmd;
    r.sample  = raw[SAMPLE_W-1:0];
    pending_readings.push_back(r);
    pushed_cnt++;
  endtask

  // Writes one clamp bound while the block is idle.
  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[SAMPLE_W-1:0];
    if (idx == CFG_CLAMP_LOW) lo_bound = val[SAMPLE_W-1:0];
    else hi_bound = val[SAMPLE_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_bounds(input int lo, input int hi);
    write_bound(CFG_CLAMP_LOW, lo);
    write_bound(CFG_CLAMP_HIGH, hi);
    setting_cnt++;
  endtask

  // Waits until every reading went in and every level came out, plus a tail
  // for calibration readings still in the pipeline.
  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != pushed_cnt || expected_levels.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Picks a reading, leaning on the range ends and the clamp edges.
  function automatic int pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = SAMPLE_MAX;
      2: v = int'(lo_bound) + int'($urandom_range(0, 2)) - 1;
      3: v = int'(hi_bound) + int'($urandom_range(0, 2)) - 1;
      default: v = int'($urandom_range(0, SAMPLE_MAX));
    endcase
    if (v < 0) v = 0;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  // Mostly complete calibration runs and sense bursts, with some broken runs.
  task automatic queue_random(input int n);
    int done;
    int kind;
    int len;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        for (int k = 0; k < CALIB_RUN; k++) queue_reading(CMD_CALIB, pick_sample());
        done += CALIB_RUN;
      end else if (kind == 2) begin
        len = $urandom_range(1, CALIB_RUN - 1);
        for (int k = 0; k < len; k++) queue_reading(CMD_CALIB, pick_sample());
        queue_reading(CMD_SENSE, pick_sample());
        done += len + 1;
      end else begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) queue_reading(CMD_SENSE, pick_sample());
        done += len;
      end
    end
  endtask

  // Driver: offers the pending readings with a random gap after each transaction, none in burst phases.
  always @(negedge clk) begin
    reading_t cur;
    logic     nxt_valid;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else if (in_valid && !in_took) begin
      nxt_valid = 1'b1;
    end else begin
      if (in_took) begin
        in_took = 1'b0;
        in_gap  = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (in_gap == 0 && pending_readings.size() != 0) begin
        cur = pending_readings.pop_front();
        in_command <= cur.command;
        in_sample  <= cur.sample;
        nxt_valid = 1'b1;
      end else begin
        if (in_gap > 0) in_gap--;
        in_sample <= SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        nxt_valid = 1'b0;
      end
    end
    in_valid <= nxt_valid;
  end

  // Receiver: stalls a random count after each result (none in the burst phase), or for a long hold-off.
  always @(negedge clk) begin
    logic nxt_stall;
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (out_took) begin
      out_took = 1'b0;
      out_wait = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else if (out_wait > 0) begin
      out_wait--;
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = 1'b0;
    end
    out_stall <= nxt_stall;
  end

  // Monitor: checks each result, then predicts from each accepted reading.
  always @(posedge clk) begin
    logic signed [LEVEL_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      out_took = 1'b1;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("level %0d with no result expected", out_level));
      end else begin
        want = expected_levels.pop_front();
        if (out_level !== want) begin
          report_mismatch($sformatf("level %0d, expected %0d", out_level, want));
        end
        checked_cnt++;
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      predict_level(in_command, in_sample);
      accepted_cnt++;
      in_took = 1'b1;
    end
  end

  // Watchdog.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("clamped_moving_average_offset test failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int lo;
    int hi;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    ring_sum   = '0;
    ring_ptr   = 0;
    cal_offset = '0;
    cal_peak   = '0;
    cal_seen   = 0;
    lo_bound   = CLAMP_LOW_RST;
    hi_bound   = CLAMP_HIGH_RST;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Fill ramp from the cleared ring, with both range ends.
    queue_reading(CMD_SENSE, SAMPLE_MAX);
    queue_reading(CMD_SENSE, SAMPLE_MAX);
    queue_reading(CMD_SENSE, 0);
    queue_reading(CMD_SENSE, 512);
    // A full calibration run that starts low and peaks at full scale.
    queue_reading(CMD_CALIB, 7);
    queue_reading(CMD_CALIB, SAMPLE_MAX);
    for (int k = 0; k < CALIB_RUN - 2; k++) queue_reading(CMD_CALIB, 0);
    queue_reading(CMD_SENSE, 0);
    // A run cut short by a sense reading keeps the old offset.
    for (int k = 0; k < 3; k++) queue_reading(CMD_CALIB, 3);
    queue_reading(CMD_SENSE, SAMPLE_MAX);
    wait_idle();

    // Crossed bounds: the low bound is tested first.
    set_bounds(600, 300);
    queue_reading(CMD_SENSE, 100);
    queue_reading(CMD_SENSE, 450);
    queue_reading(CMD_SENSE, 900);
    wait_idle();

    // Random phases over several clamp settings and idling patterns.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin lo = 0; hi = SAMPLE_MAX; end
        1: begin lo = $urandom_range(0, 500); hi = $urandom_range(lo, SAMPLE_MAX); end
        2: begin lo = SAMPLE_MAX; hi = SAMPLE_MAX; end
        3: begin lo = 0; hi = 0; end
        4: begin hi = $urandom_range(0, 500); lo = $urandom_range(hi + 1, SAMPLE_MAX); end
        default: begin lo = $urandom_range(0, SAMPLE_MAX); hi = $urandom_range(0, SAMPLE_MAX); end
      endcase
      set_bounds(lo, hi);
      tx_burst = (ph % 2 == 1);
      rx_burst = (ph == 3);
      // Hold the output off while the sender keeps pushing.
      if (ph == 1) begin
        @(posedge clk);
        hold_req = 1'b1;
      end
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    if (expected_levels.size() != 0) begin
      report_mismatch($sformatf("%0d levels never arrived", expected_levels.size()));
    end
    $display("Sent %0d readings over %0d clamp settings; %0d levels checked, %0d offsets set.",
             accepted_cnt, setting_cnt + 1, checked_cnt, commit_cnt);
    $display("Mismatches: %0d, cycles used: %0d.", err_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("clamped_moving_average_offset test passed");
    end else begin
      $display("clamped_moving_average_offset test failed");
    end
    $finish;
  end

endmodule
